@@ hw/rtl/iirpn_pkg.sv @@
// ---------------------------------------------------------------------------
// iirpn_pkg
// Shared types, operation codes and coefficient tables for the pink-noise
// shaping IIR filter.
// ---------------------------------------------------------------------------
package iirpn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int COEF_W   = 18;            // signed Q2.16
  localparam int OPA_W    = 32;
  localparam int PROD_W   = OPA_W + COEF_W;
  localparam int ACC_W    = 56;
  localparam int TAP_W    = 4;             // tap index, up to 16 taps

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  // multiplier operations
  localparam logic [1:0] OP_X0   = 2'd0;   // newest sample times b0
  localparam logic [1:0] OP_FF   = 2'd1;   // past input times b[k]
  localparam logic [1:0] OP_FB   = 2'd2;   // past output times a[k]
  localparam logic [1:0] OP_GAIN = 2'd3;   // filter value times gain

  typedef struct packed {
    logic             load;      // take a new sample, clear accumulator
    logic             mul_en;    // issue one multiply
    logic [1:0]       op;
    logic [TAP_W-1:0] tap;
    logic             round_en;  // round filter value, shift histories
    logic             out_load;  // write the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;              // output register holds an untaken item
  } dp_status_t;

  // feedforward coefficients b[0..6], zero above
  function automatic logic signed [COEF_W-1:0] coef_ff(input logic [TAP_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      4'd0:    c = 18'sd65461;
      4'd1:    c = 18'sd65098;
      4'd2:    c = 18'sd63504;
      4'd3:    c = 18'sd56787;
      4'd4:    c = 18'sd36045;
      4'd5:    c = -18'sd49912;
      4'd6:    c = 18'sd7597;
      default: c = '0;
    endcase
    return c;
  endfunction

  // feedback coefficients a[1..6], leading 1.0 not stored
  function automatic logic signed [COEF_W-1:0] coef_fb(input logic [TAP_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      4'd1:    c = -18'sd110854;
      4'd2:    c = 18'sd58511;
      4'd3:    c = -18'sd20264;
      4'd4:    c = 18'sd13042;
      4'd5:    c = -18'sd10525;
      4'd6:    c = 18'sd6980;
      default: c = '0;
    endcase
    return c;
  endfunction

  // clamp a wide signed value to signed 32 bits
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > $signed({{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}})) begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (v < $signed({{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}})) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/iirpn_ctrl.sv @@
// ---------------------------------------------------------------------------
// iirpn_ctrl
// Sequencer for the shared multiplier: the newest sample, then a feedforward
// and a feedback product per past tap, rounding, gain and output write.
// ---------------------------------------------------------------------------
module iirpn_ctrl
  import iirpn_pkg::*;
#(
  parameter int TAPS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  localparam int TW = $clog2(TAPS);
  localparam logic [TW-1:0] LAST_TAP = TW'(TAPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_X0    = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_GAIN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state, state_next;
  logic [TW-1:0] tap, tap_next;
  logic          fb_phase, fb_phase_next;

  // state and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tap      <= '0;
      fb_phase <= 1'b0;
    end else begin
      state    <= state_next;
      tap      <= tap_next;
      fb_phase <= fb_phase_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    tap_next      = tap;
    fb_phase_next = fb_phase;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.tap       = TAP_W'(tap);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_X0;
        end
      end
      S_X0: begin
        cmd.mul_en    = 1'b1;
        cmd.op        = OP_X0;
        tap_next      = TW'(1);
        fb_phase_next = 1'b0;
        state_next    = S_MAC;
      end
      S_MAC: begin
        cmd.mul_en    = 1'b1;
        cmd.op        = fb_phase ? OP_FB : OP_FF;
        fb_phase_next = ~fb_phase;
        if (fb_phase) begin
          tap_next = tap + TW'(1);
          if (tap == LAST_TAP) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        state_next   = S_GAIN;
      end
      S_GAIN: begin
        cmd.mul_en = 1'b1;
        cmd.op     = OP_GAIN;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/iirpn_dp.sv @@
// ---------------------------------------------------------------------------
// iirpn_dp
// Datapath: sample and history registers, one shared 32x18 multiplier,
// accumulator, rounding and saturation, gain register and output register.
// ---------------------------------------------------------------------------
module iirpn_dp
  import iirpn_pkg::*;
#(
  parameter int TAPS = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       gain_wr_en,
  input  logic        [GAIN_W-1:0]   gain_wr_data,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    sample_out
);

  localparam int HD = TAPS - 1;
  localparam int HW = (HD > 1) ? $clog2(HD) : 1;

  logic signed [SAMPLE_W-1:0] x_reg;
  logic signed [SAMPLE_W-1:0] in_hist  [HD];
  logic signed [OUT_W-1:0]    out_hist [HD];
  logic signed [OUT_W-1:0]    y_reg;
  logic        [GAIN_W-1:0]   gain;
  logic signed [OPA_W-1:0]    opa;
  logic signed [COEF_W-1:0]   opb;
  logic signed [PROD_W-1:0]   prod;
  logic                       prod_acc, prod_sub;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [ACC_W-1:0]    gain_rnd;
  logic signed [OUT_W-1:0]    y_next;
  logic        [HW-1:0]       hsel;

  assign hsel = HW'(cmd.tap - TAP_W'(1));

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (gain_wr_en) begin
      gain <= gain_wr_data;
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_X0: begin
        opa = OPA_W'(x_reg);
        opb = coef_ff(TAP_W'(0));
      end
      OP_FF: begin
        opa = OPA_W'(in_hist[hsel]);
        opb = coef_ff(cmd.tap);
      end
      OP_FB: begin
        opa = out_hist[hsel];
        opb = coef_fb(cmd.tap);
      end
      default: begin
        opa = y_reg;
        opb = $signed({{(COEF_W-GAIN_W){1'b0}}, gain});
      end
    endcase
  end

  // registered product and its accumulate tag
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_acc <= 1'b0;
      prod_sub <= 1'b0;
    end else begin
      prod_acc <= cmd.mul_en && (cmd.op != OP_GAIN);
      prod_sub <= (cmd.op == OP_FB);
    end
    if (cmd.mul_en) begin
      prod <= opa * opb;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc   <= '0;
      x_reg <= sample_in;
    end else if (prod_acc) begin
      if (prod_sub) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // round to 15 fractional bits and saturate
  assign acc_rnd = acc + ACC_W'(32768);
  assign y_next  = sat32(acc_rnd >>> 16);

  // filter value and history shift lines
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HD; i++) begin
        in_hist[i]  <= '0;
        out_hist[i] <= '0;
      end
    end else if (cmd.round_en) begin
      in_hist[0]  <= x_reg;
      out_hist[0] <= y_next;
      for (int i = 1; i < HD; i++) begin
        in_hist[i]  <= in_hist[i-1];
        out_hist[i] <= out_hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      y_reg <= y_next;
    end
  end

  // gain product rounding and output register
  assign gain_rnd = ACC_W'(prod) + ACC_W'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      sample_out <= sat32(gain_rnd >>> 8);
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

@@ hw/rtl/iir_pink_noise_filter.sv @@
// ---------------------------------------------------------------------------
// iir_pink_noise_filter
// Sixth-order direct-form-I IIR filter shaping its input toward a pink
// spectrum, with a programmable output gain.
// ---------------------------------------------------------------------------
// Each input item (signed Q1.15 sample) gives one output item (signed,
// 15 fractional bits, saturated to 32 bits): the filter value times the
// unsigned Q8.8 gain. All products go through one shared 32x18 multiplier:
// the newest sample first, then a feedforward and a feedback product per
// past tap, then pipeline drain, rounding, the gain product and the output
// write. The input is ready again the cycle after that write, so a new
// item is only taken once the previous one has been written out. While the
// previous result still waits in the output register, the output write and
// with it the next acceptance are held off. Both histories clear at reset;
// gain resets to 256 (unity); the user must write it only while the block
// is idle, as the block itself does not enforce this.
// ---------------------------------------------------------------------------
module iir_pink_noise_filter
  import iirpn_pkg::*;
#(
  parameter int TAPS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // [15:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,      // [31:0] sample_out
  input  logic        gain_wr_en,
  input  logic [15:0] gain_wr_data
);

  dp_cmd_t                 cmd;
  dp_status_t              status;
  logic signed [OUT_W-1:0] sample_out;

  // controller
  iirpn_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath
  iirpn_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample_in    ($signed(s_tdata)),
    .gain_wr_en   (gain_wr_en),
    .gain_wr_data (gain_wr_data),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .sample_out   (sample_out)
  );

  assign m_tdata = sample_out;

endmodule

@@ verif/iir_pink_noise_filter_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iir_pink_noise_filter_test
// Self-checking bench for the pink-noise shaping IIR filter. A short table of
// samples covers the input extremes, unity, zero and full-scale gain, and a
// fresh filter after reset. Random samples then run in phases, one gain per
// phase. Each output item is checked against a bit-exact fixed-point model of
// the filter and its gain stage, or against the table's result on a typed
// row. Input bursts, output stalls and one long output hold-off are applied.
// ---------------------------------------------------------------------------
module iir_pink_noise_filter_test
  import iirpn_pkg::*;
();

  localparam int HIST_DEPTH    = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 12;
  localparam int DIR_ROWS      = 21;
  localparam longint OUT_MAX   = 64'sd2147483647;
  localparam longint OUT_MIN   = -64'sd2147483648;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;      // [15:0] sample_in
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;           // [31:0] sample_out
  logic                gain_wr_en = 1'b0;
  logic [GAIN_W-1:0]   gain_wr_data = '0;

  iir_pink_noise_filter dut (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .gain_wr_en   (gain_wr_en),
    .gain_wr_data (gain_wr_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter coefficients, signed Q2.16
  int ff_coef [0:6] = '{65461, 65098, 63504, 56787, 36045, -49912, 7597};
  int fb_coef [0:6] = '{0, -110854, 58511, -20264, 13042, -10525, 6980};

  // model state
  logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
  logic signed [OUT_W-1:0]    y_hist [HIST_DEPTH];
  logic [GAIN_W-1:0]          gain_now = GAIN_RESET;

  logic [OUT_W-1:0] expected_out [$];

  int  mismatches    = 0;
  int  samples_sent  = 0;
  int  outputs_seen  = 0;
  int  gain_writes   = 0;
  int  filter_clips  = 0;
  int  output_clips  = 0;
  int  burst_left    = 0;
  bit  gaps_on       = 1'b1;
  logic [SAMPLE_W-1:0] last_sample = '0;

  // receiver control
  logic hold_token = 1'b0;
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;
  int   rx_mode    = 0;
  int   rx_left    = 0;

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
  end

  // directed samples: set_gain, gain, sample, typed, result
  typedef struct packed {
    logic                set_gain;
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    logic [OUT_W-1:0]    result;
  } step_row_t;

  step_row_t dir_rows [DIR_ROWS] = '{
    // fresh filter, only b0 contributes to the first row
    '{1'b0, 16'd0,     16'h8000, 1'b1, 32'hFFFF8026},
    '{1'b0, 16'd0,     16'h7FFF, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h7FFF, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h0000, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h8000, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h0001, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'hFFFF, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h5555, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'hAAAA, 1'b0, 32'h0},
    // zero gain mutes the output, histories keep moving
    '{1'b1, 16'd0,     16'h7FFF, 1'b1, 32'h0},
    '{1'b0, 16'd0,     16'h8000, 1'b1, 32'h0},
    '{1'b0, 16'd0,     16'h1234, 1'b1, 32'h0},
    // full-scale gain
    '{1'b1, 16'hFFFF,  16'h7FFF, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h7FFF, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h8000, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h8000, 1'b0, 32'h0},
    // smallest nonzero gain
    '{1'b1, 16'd1,     16'h7FFF, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h8000, 1'b0, 32'h0},
    // back to unity
    '{1'b1, 16'd256,   16'h0000, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h0000, 1'b0, 32'h0},
    '{1'b0, 16'd0,     16'h0000, 1'b0, 32'h0}
  };

  function automatic longint clamp32(input longint v);
    if (v > OUT_MAX) return OUT_MAX;
    if (v < OUT_MIN) return OUT_MIN;
    return v;
  endfunction

  // one filter step: returns the gained output and advances the histories
  function automatic logic [OUT_W-1:0] pink_filter_next(input logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint wide;
    longint g;
    logic signed [OUT_W-1:0] y;
    acc = longint'(ff_coef[0]) * longint'(x);
    for (int i = 1; i <= HIST_DEPTH; i++) begin
      acc += longint'(ff_coef[i]) * longint'(x_hist[i-1]);
      acc -= longint'(fb_coef[i]) * longint'(y_hist[i-1]);
    end
    // round 31 fractional bits down to 15
    wide = (acc + 64'sd32768) >>> 16;
    if (wide != clamp32(wide)) filter_clips++;
    y = OUT_W'(clamp32(wide));
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      x_hist[i] = x_hist[i-1];
      y_hist[i] = y_hist[i-1];
    end
    x_hist[0] = x;
    y_hist[0] = y;
    // gain stage, Q8.8 with rounding
    g = longint'(gain_now);
    wide = (longint'(y) * g + 64'sd128) >>> 8;
    if (wide != clamp32(wide)) output_clips++;
    return OUT_W'(clamp32(wide));
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    mismatches++;
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what,
             $signed(got), $signed(want));
  endtask

  // offer one sample until taken, then maybe go quiet for a while
  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input bit typed,
                           input logic [OUT_W-1:0] want);
    logic [OUT_W-1:0] predicted;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = pink_filter_next(smp);
    expected_out.push_back(typed ? want : predicted);
    samples_sent++;
    last_sample = smp;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if (gaps_on) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for the filter to go idle
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    gain_wr_en   <= 1'b1;
    gain_wr_data <= g;
    @(posedge clk);
    gain_wr_en <= 1'b0;
    gain_now = g;
    gain_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int kind;
    kind = $urandom_range(0, 15);
    case (kind)
      8, 9: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      10, 11: begin
        return SAMPLE_W'($signed($urandom_range(0, 127)) - 64);
      end
      12, 13: begin
        return last_sample;        // constant runs push the feedback
      end
      14: begin
        return '0;
      end
      default: begin
        return SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  // receiver: changing stall patterns plus a long hold-off on request
  always @(posedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_left % 5 != 0);
        endcase
      end
    end
  end

  // compare each output item with the oldest expected value
  always @(posedge clk) begin : result_check
    logic [OUT_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      outputs_seen++;
      if (expected_out.size() == 0) begin
        report_mismatch("output item with nothing pending", m_tdata, '0);
      end else begin
        want = expected_out.pop_front();
        if (m_tdata !== want) report_mismatch("sample_out", m_tdata, want);
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [GAIN_W-1:0] gain_plan [PHASES];
    int count;
    gain_plan = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd128, GAIN_W'($urandom),
                  16'd512, 16'h8000, GAIN_W'($urandom), 16'd256, 16'hFFFF,
                  GAIN_W'($urandom)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].set_gain) begin
        finish_phase();
        write_gain(dir_rows[r].gain);
      end
      send_item(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].result);
    end

    // random phases, one gain each
    for (int p = 0; p < PHASES; p++) begin
      finish_phase();
      write_gain(gain_plan[p]);
      gaps_on = (p % 3 != 1) && (p != 4);
      if (p == 4) hold_token <= ~hold_token;   // long output hold-off
      count = $urandom_range(110, 140);
      for (int k = 0; k < count; k++) begin
        send_item(random_sample(), 1'b0, '0);
      end
    end

    finish_phase();
    $display("ran %0d samples over %0d gain writes, %0d outputs compared",
             samples_sent, gain_writes, outputs_seen);
    $display("filter value clipped %0d times, gained output clipped %0d times",
             filter_clips, output_clips);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("timeout with %0d outputs still pending", expected_out.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ iir_pink_noise_filter.f @@
hw/rtl/iirpn_pkg.sv
hw/rtl/iirpn_ctrl.sv
hw/rtl/iirpn_dp.sv
hw/rtl/iir_pink_noise_filter.sv
verif/iir_pink_noise_filter_test.sv
